// ===== rtl/cbe_pkg.sv =====
// cbe_pkg: shared types and constants for the cubic bezier easing solver
// used by the register file, the controller and the datapath; no dependencies
`default_nettype none
package cbe_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CTRL1_X     = 3'd0,
      CSR_CTRL1_Y     = 3'd1,
      CSR_CTRL2_X     = 3'd2,
      CSR_CTRL2_Y     = 3'd3,
      CSR_TOLERANCE   = 3'd4,
      CSR_START_VALUE = 3'd5,
      CSR_END_VALUE   = 3'd6
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [16:0]        CTRL1_X_RST     = 17'd0;
   localparam logic signed [19:0] CTRL1_Y_RST     = 20'sd0;
   localparam logic [16:0]        CTRL2_X_RST     = 17'd65536;
   localparam logic signed [19:0] CTRL2_Y_RST     = 20'sd65536;
   localparam logic [16:0]        TOLERANCE_RST   = 17'd328;
   localparam logic signed [31:0] START_VALUE_RST = 32'sd0;
   localparam logic signed [31:0] END_VALUE_RST   = 32'sd65536;

   // saturation limits of the Q1.16 / Q3.16 fields
   localparam logic [16:0]        TIME_MAX = 17'd65536;
   localparam logic signed [19:0] EY_MAX   = 20'sd262144;

   typedef struct packed {
      logic [16:0]        ctrl1_x;
      logic signed [19:0] ctrl1_y;
      logic [16:0]        ctrl2_x;
      logic signed [19:0] ctrl2_y;
      logic [16:0]        tolerance;
      logic signed [31:0] start_value;
      logic signed [31:0] end_value;
   } cfg_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_N_CHECK,
      ST_NP_SET, ST_NP_M1, ST_NP_M2, ST_NP_M3, ST_NP_TEST,
      ST_ND_SET, ST_ND_M1, ST_ND_M2, ST_ND_TEST, ST_DIV, ST_N_UPD,
      ST_B_INIT, ST_B_CHECK, ST_B_SET, ST_B_M1, ST_B_M2, ST_B_M3, ST_B_TEST,
      ST_Y_SET, ST_Y_M1, ST_Y_M2, ST_Y_M3, ST_EY, ST_OUT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_ACC_SET, DP_MAC, DP_SAVE_DX, DP_DIV_START,
      DP_DIV_STEP, DP_NEWTON_UPD, DP_BIS_INIT, DP_BIS_UPD, DP_EY, DP_OUT
   } dp_op_type;

   // coefficient operand select
   typedef enum logic [3:0] {
      SEL_AX, SEL_BX, SEL_CX, SEL_AX3, SEL_BX2, SEL_AY, SEL_BY, SEL_CY, SEL_ZERO
   } coef_sel_type;

   typedef struct packed {
      dp_op_type    op;
      coef_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic near;      // |acc - x| below tolerance
      logic acc_zero;  // accumulator exactly zero
      logic lo_lt_hi;  // bisection bracket still open
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/cubic_bezier_easing_solver.sv =====
// cubic_bezier_easing_solver: top level of the cubic bezier easing solver
// depends on cbe_pkg, cbe_csr, cbe_ctrl and cbe_dp
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   time_progress
//   rsp_      out        rsp_valid/rsp_stall   curve_param, eased_progress, value
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one request at a time; a Newton step makes two horner passes on the shared
// multiplier plus a serial division at one quotient bit per cycle; bisection
// steps follow if Newton does not converge, then the final y and interpolation.
// the result is loaded once the output register is free.
// reset is synchronous and restores the register defaults; the result register
// holds under rsp_stall while the next request is already being taken.
`default_nettype none
module cubic_bezier_easing_solver #(
   parameter int NEWTON_STEPS = 8,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [16:0]        req_time_progress,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [16:0]             rsp_curve_param,
   output logic signed [19:0]      rsp_eased_progress,
   output logic signed [31:0]      rsp_value,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import cbe_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   cbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbe_ctrl #(
      .NEWTON_STEPS (NEWTON_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbe_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_time_progress  (req_time_progress),
      .rsp_curve_param    (rsp_curve_param),
      .rsp_eased_progress (rsp_eased_progress),
      .rsp_value          (rsp_value)
   );

   // busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("solver not busy after request");

   // a new result only appears at the end of a solve
   a_rsp_from_solve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a running solve");

   // solved t stays within the unit interval
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_curve_param <= TIME_MAX))
      else $error("curve parameter above one");

   // eased progress stays within its saturation limits
   a_ey_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eased_progress <= EY_MAX && rsp_eased_progress >= -EY_MAX))
      else $error("eased progress out of range");

endmodule
`default_nettype wire

// ===== rtl/cbe_csr.sv =====
// cbe_csr: configuration register file of the easing solver
// depends on cbe_pkg
`default_nettype none
module cbe_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_wdata,
   output cbe_pkg::cfg_type          cfg
);
   import cbe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CTRL1_X:     cfg_in.ctrl1_x     = csr_wdata[16:0];
            CSR_CTRL1_Y:     cfg_in.ctrl1_y     = signed'(csr_wdata[19:0]);
            CSR_CTRL2_X:     cfg_in.ctrl2_x     = csr_wdata[16:0];
            CSR_CTRL2_Y:     cfg_in.ctrl2_y     = signed'(csr_wdata[19:0]);
            CSR_TOLERANCE:   cfg_in.tolerance   = csr_wdata[16:0];
            CSR_START_VALUE: cfg_in.start_value = signed'(csr_wdata);
            CSR_END_VALUE:   cfg_in.end_value   = signed'(csr_wdata);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctrl1_x     <= CTRL1_X_RST;
         cfg_ff.ctrl1_y     <= CTRL1_Y_RST;
         cfg_ff.ctrl2_x     <= CTRL2_X_RST;
         cfg_ff.ctrl2_y     <= CTRL2_Y_RST;
         cfg_ff.tolerance   <= TOLERANCE_RST;
         cfg_ff.start_value <= START_VALUE_RST;
         cfg_ff.end_value   <= END_VALUE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cbe_ctrl.sv =====
// cbe_ctrl: sequencer for newton steps, bisection and curve sampling
// depends on cbe_pkg; drives the datapath cbe_dp by command struct
`default_nettype none
module cbe_ctrl #(
   parameter int NEWTON_STEPS = 8,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire cbe_pkg::dp_status_type status,
   output cbe_pkg::dp_cmd_type         cmd
);
   import cbe_pkg::*;

   localparam int NW       = $clog2(NEWTON_STEPS + 2);
   localparam int SW       = $clog2(FRAC_BITS + 3);
   localparam int DIV_LAST = FRAC_BITS + 1;   // quotient has FRAC_BITS+2 bits
   localparam int BIS_MAX  = FRAC_BITS + 1;

   state_type         state_ff, state_in;
   logic [NW-1:0]     ncnt_ff, ncnt_in;
   logic [SW-1:0]     scnt_ff, scnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ncnt_ff      <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ncnt_ff      <= ncnt_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      ncnt_in      = ncnt_ff;
      scnt_in      = scnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = DP_NOP;
      cmd.sel      = SEL_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               ncnt_in  = '0;
               state_in = ST_N_CHECK;
            end
         end
         ST_N_CHECK: begin
            if (ncnt_ff == NW'(NEWTON_STEPS)) state_in = ST_B_INIT;
            else                              state_in = ST_NP_SET;
         end
         // newton: x(t)
         ST_NP_SET: begin
            cmd.op = DP_ACC_SET; cmd.sel = SEL_AX; state_in = ST_NP_M1;
         end
         ST_NP_M1: begin
            cmd.op = DP_MAC; cmd.sel = SEL_BX; state_in = ST_NP_M2;
         end
         ST_NP_M2: begin
            cmd.op = DP_MAC; cmd.sel = SEL_CX; state_in = ST_NP_M3;
         end
         ST_NP_M3: begin
            cmd.op = DP_MAC; cmd.sel = SEL_ZERO; state_in = ST_NP_TEST;
         end
         ST_NP_TEST: begin
            if (status.near) begin
               state_in = ST_Y_SET;
            end else begin
               cmd.op   = DP_SAVE_DX;
               state_in = ST_ND_SET;
            end
         end
         // newton: derivative
         ST_ND_SET: begin
            cmd.op = DP_ACC_SET; cmd.sel = SEL_AX3; state_in = ST_ND_M1;
         end
         ST_ND_M1: begin
            cmd.op = DP_MAC; cmd.sel = SEL_BX2; state_in = ST_ND_M2;
         end
         ST_ND_M2: begin
            cmd.op = DP_MAC; cmd.sel = SEL_CX; state_in = ST_ND_TEST;
         end
         ST_ND_TEST: begin
            if (status.acc_zero) begin
               state_in = ST_B_INIT;
            end else begin
               cmd.op   = DP_DIV_START;
               scnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         // one quotient bit per cycle
         ST_DIV: begin
            cmd.op  = DP_DIV_STEP;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == SW'(DIV_LAST)) state_in = ST_N_UPD;
         end
         ST_N_UPD: begin
            cmd.op   = DP_NEWTON_UPD;
            ncnt_in  = ncnt_ff + 1'b1;
            state_in = ST_N_CHECK;
         end
         // bisection
         ST_B_INIT: begin
            cmd.op   = DP_BIS_INIT;
            scnt_in  = '0;
            state_in = ST_B_CHECK;
         end
         ST_B_CHECK: begin
            if (scnt_ff == SW'(BIS_MAX) || !status.lo_lt_hi) state_in = ST_Y_SET;
            else                                               state_in = ST_B_SET;
         end
         ST_B_SET: begin
            cmd.op = DP_ACC_SET; cmd.sel = SEL_AX; state_in = ST_B_M1;
         end
         ST_B_M1: begin
            cmd.op = DP_MAC; cmd.sel = SEL_BX; state_in = ST_B_M2;
         end
         ST_B_M2: begin
            cmd.op = DP_MAC; cmd.sel = SEL_CX; state_in = ST_B_M3;
         end
         ST_B_M3: begin
            cmd.op = DP_MAC; cmd.sel = SEL_ZERO; state_in = ST_B_TEST;
         end
         ST_B_TEST: begin
            if (status.near) begin
               state_in = ST_Y_SET;
            end else begin
               cmd.op   = DP_BIS_UPD;
               scnt_in  = scnt_ff + 1'b1;
               state_in = ST_B_CHECK;
            end
         end
         // curve y at the solved t
         ST_Y_SET: begin
            cmd.op = DP_ACC_SET; cmd.sel = SEL_AY; state_in = ST_Y_M1;
         end
         ST_Y_M1: begin
            cmd.op = DP_MAC; cmd.sel = SEL_BY; state_in = ST_Y_M2;
         end
         ST_Y_M2: begin
            cmd.op = DP_MAC; cmd.sel = SEL_CY; state_in = ST_Y_M3;
         end
         ST_Y_M3: begin
            cmd.op = DP_MAC; cmd.sel = SEL_ZERO; state_in = ST_EY;
         end
         ST_EY: begin
            cmd.op = DP_EY; state_in = ST_OUT;
         end
         // interpolate and load the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/cbe_dp.sv =====
// cbe_dp: datapath with coefficient registers, shared multiplier, serial divider
// depends on cbe_pkg; sequenced by cbe_ctrl
`default_nettype none
module cbe_dp #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire cbe_pkg::cfg_type       cfg,
   input  wire cbe_pkg::dp_cmd_type    cmd,
   output cbe_pkg::dp_status_type      status,
   input  wire logic [16:0]            req_time_progress,
   output logic [16:0]                 rsp_curve_param,
   output logic signed [19:0]          rsp_eased_progress,
   output logic signed [31:0]          rsp_value
);
   import cbe_pkg::*;

   localparam int DW    = FRAC_BITS + 12;          // coefficients and accumulator
   localparam int TW    = FRAC_BITS + 2;           // t values, quotient bits
   localparam int MA    = (DW > 33) ? DW : 33;
   localparam int MB    = (TW > 20) ? TW : 20;
   localparam int PW    = MA + MB;
   localparam bit UP    = (FRAC_BITS >= 16);
   localparam int SH_UP = UP ? FRAC_BITS - 16 : 0;
   localparam int SH_DN = UP ? 1 : 16 - FRAC_BITS;
   localparam int SH_OUT_DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 1;
   localparam int SH_OUT_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int EW    = DW + 8;

   localparam logic signed [DW-1:0] ONE_D   = DW'(1) <<< FRAC_BITS;
   localparam logic signed [TW-1:0] ONE_T   = TW'(1) <<< FRAC_BITS;
   localparam logic signed [PW-1:0] HALF_F  = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] HALF_16 = PW'(1) <<< 15;
   localparam logic signed [PW-1:0] VAL_MAX = PW'(64'sd2147483647);
   localparam logic signed [PW-1:0] VAL_MIN = -PW'(64'sd2147483648);

   // Q16 to working format, rounding when bits are dropped
   function automatic logic signed [DW-1:0] to_qf(input logic signed [19:0] v);
      logic signed [DW:0] w;
      w = (DW + 1)'(v);
      if (UP) to_qf = DW'(w <<< SH_UP);
      else    to_qf = DW'((w + ((DW + 1)'(1) <<< (SH_DN - 1))) >>> SH_DN);
   endfunction

   logic signed [DW-1:0] ax_ff, bx_ff, cx_ff, ay_ff, by_ff, cy_ff;
   logic signed [DW-1:0] ax_in, bx_in, cx_in, ay_in, by_in, cy_in;
   logic signed [DW-1:0] eps_ff, acc_ff, dx_ff;
   logic signed [TW-1:0] x_ff, t_ff, t0_ff, t1_ff;
   logic        [DW-1:0] dabs_ff, rem_ff;
   logic        [TW-1:0] sh_ff, quo_ff;
   logic                 ovf_ff, neg_ff;
   logic signed [19:0]   ey_ff;

   logic signed [DW-1:0] p1x, p2x, p1y, p2y, x_qf;
   logic        [16:0]   x16;
   logic signed [DW-1:0] addend;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic signed [PW-1:0] prod, rnd_f, rnd_16, val_w;
   logic signed [DW:0]   diff, diff_abs;
   logic        [DW-1:0] dx_abs, d_abs;
   logic        [DW:0]   rem_sh;
   logic signed [TW+2:0] q_s, t_new;
   logic signed [TW:0]   lo_n, hi_n, mid;
   logic signed [EW-1:0] ey_w;
   logic signed [TW:0]   t_out;

   // coefficients from the control points
   always_comb begin
      p1x   = to_qf(signed'({3'b000, cfg.ctrl1_x}));
      p2x   = to_qf(signed'({3'b000, cfg.ctrl2_x}));
      p1y   = to_qf(cfg.ctrl1_y);
      p2y   = to_qf(cfg.ctrl2_y);
      cx_in = DW'(3 * p1x);
      bx_in = DW'(3 * (p2x - p1x)) - cx_in;
      ax_in = ONE_D - cx_in - bx_in;
      cy_in = DW'(3 * p1y);
      by_in = DW'(3 * (p2y - p1y)) - cy_in;
      ay_in = ONE_D - cy_in - by_in;
      x16   = (req_time_progress > TIME_MAX) ? TIME_MAX : req_time_progress;
      x_qf  = to_qf(signed'({3'b000, x16}));
   end

   // operand select
   always_comb begin
      unique case (cmd.sel)
         SEL_AX:   addend = ax_ff;
         SEL_BX:   addend = bx_ff;
         SEL_CX:   addend = cx_ff;
         SEL_AX3:  addend = DW'(3 * ax_ff);
         SEL_BX2:  addend = bx_ff <<< 1;
         SEL_AY:   addend = ay_ff;
         SEL_BY:   addend = by_ff;
         SEL_CY:   addend = cy_ff;
         default:  addend = '0;
      endcase
   end

   // shared multiplier: horner step or final span scaling
   always_comb begin
      if (cmd.op == DP_OUT) begin
         mul_a = MA'(33'(cfg.end_value) - 33'(cfg.start_value));
         mul_b = MB'(ey_ff);
      end else begin
         mul_a = MA'(acc_ff);
         mul_b = MB'(t_ff);
      end
      prod   = mul_a * mul_b;
      rnd_f  = (prod + HALF_F) >>> FRAC_BITS;
      rnd_16 = (prod + HALF_16) >>> 16;
      val_w  = PW'(cfg.start_value) + rnd_16;
   end

   // status toward the controller
   always_comb begin
      diff            = (DW + 1)'(acc_ff) - (DW + 1)'(x_ff);
      diff_abs        = diff[DW] ? -diff : diff;
      status.near     = diff_abs < (DW + 1)'(eps_ff);
      status.acc_zero = (acc_ff == '0);
      status.lo_lt_hi = t0_ff < t1_ff;
   end

   // divider, newton update and bisection helpers
   always_comb begin
      dx_abs = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      d_abs  = acc_ff[DW-1] ? DW'(-acc_ff) : DW'(acc_ff);
      rem_sh = {rem_ff, sh_ff[TW-1]};
      q_s    = signed'({3'b000, quo_ff});
      t_new  = (TW + 3)'(t_ff) - (neg_ff ? -q_s : q_s);
      // curve below target moves the lower bound up
      if (acc_ff < DW'(x_ff)) begin
         lo_n = (TW + 1)'(t_ff);
         hi_n = (TW + 1)'(t1_ff);
      end else begin
         lo_n = (TW + 1)'(t0_ff);
         hi_n = (TW + 1)'(t_ff);
      end
      mid = ((hi_n - lo_n) >>> 1) + lo_n;
      if (FRAC_BITS > 16)
         ey_w = EW'(((EW)'(acc_ff) + (EW'(1) <<< (SH_OUT_DN - 1))) >>> SH_OUT_DN);
      else
         ey_w = EW'(acc_ff) <<< SH_OUT_UP;
      if (FRAC_BITS > 16)
         t_out = ((TW + 1)'(t_ff) + ((TW + 1)'(1) <<< (SH_OUT_DN - 1))) >>> SH_OUT_DN;
      else
         t_out = (TW + 1)'(t_ff) <<< SH_OUT_UP;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_LOAD: begin
            ax_ff  <= ax_in;  bx_ff <= bx_in;  cx_ff <= cx_in;
            ay_ff  <= ay_in;  by_ff <= by_in;  cy_ff <= cy_in;
            eps_ff <= to_qf(signed'({3'b000, cfg.tolerance}));
            x_ff   <= TW'(x_qf);
            t_ff   <= TW'(x_qf);
         end
         DP_ACC_SET: acc_ff <= addend;
         DP_MAC:     acc_ff <= DW'(rnd_f) + addend;
         DP_SAVE_DX: dx_ff  <= acc_ff - DW'(x_ff);
         DP_DIV_START: begin
            dabs_ff <= d_abs;
            rem_ff  <= dx_abs >> 2;
            ovf_ff  <= (dx_abs >> 2) >= d_abs;
            sh_ff   <= {dx_abs[1:0], {FRAC_BITS{1'b0}}};
            neg_ff  <= dx_ff[DW-1] ^ acc_ff[DW-1];
            quo_ff  <= '0;
         end
         DP_DIV_STEP: begin
            if (rem_sh >= (DW + 1)'(dabs_ff)) begin
               rem_ff <= DW'(rem_sh - (DW + 1)'(dabs_ff));
               quo_ff <= {quo_ff[TW-2:0], 1'b1};
            end else begin
               rem_ff <= DW'(rem_sh);
               quo_ff <= {quo_ff[TW-2:0], 1'b0};
            end
            sh_ff <= sh_ff << 1;
         end
         DP_NEWTON_UPD: begin
            if (ovf_ff)                        t_ff <= neg_ff ? ONE_T : '0;
            else if (t_new < 0)                t_ff <= '0;
            else if (t_new > (TW + 3)'(ONE_T)) t_ff <= ONE_T;
            else                               t_ff <= TW'(t_new);
         end
         DP_BIS_INIT: begin
            t0_ff <= '0;
            t1_ff <= ONE_T;
            t_ff  <= x_ff;
         end
         DP_BIS_UPD: begin
            t0_ff <= TW'(lo_n);
            t1_ff <= TW'(hi_n);
            t_ff  <= TW'(mid);
         end
         DP_EY: begin
            if (ey_w > EW'(EY_MAX))       ey_ff <= EY_MAX;
            else if (ey_w < -EW'(EY_MAX)) ey_ff <= -EY_MAX;
            else                          ey_ff <= 20'(ey_w);
         end
         DP_OUT: begin
            rsp_curve_param    <= 17'(t_out);
            rsp_eased_progress <= ey_ff;
            if (val_w > VAL_MAX)      rsp_value <= 32'(VAL_MAX);
            else if (val_w < VAL_MIN) rsp_value <= 32'(VAL_MIN);
            else                      rsp_value <= 32'(val_w);
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire
